// ===== src/pcq_pkg.sv =====
// Shared types and codes for the polygon corner quality block.
// Used by the front, back and top-level modules; depends on nothing.
`default_nettype none

package pcq_pkg;

  // Kind of work carried from the front to the back through the queue.
  typedef enum logic [0:0] {
    KIND_CORNER = 1'b0,
    KIND_FINISH = 1'b1
  } pcq_kind_t;

  // Control part of one queued job.
  typedef struct packed {
    pcq_kind_t kind;
    logic      is_tri;
  } pcq_ctrl_t;

  localparam int unsigned CTRL_BITS = $bits(pcq_ctrl_t);

endpackage

`default_nettype wire

// ===== src/pcq_fifo.sv =====
// Two-entry job queue between the front and the back part.
// Depends on nothing but its width parameter.
`default_nettype none

module pcq_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_word,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_word
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_word   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage is written at the write pointer.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pcq_front.sv =====
// Front part: accepts vertices, tracks the polygon's points and issues
// corner jobs (edge vector pairs) and a finish job. Uses pcq_pkg.
`default_nettype none

module pcq_front #(
  parameter int unsigned CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [3*CW-1:0]      in_pos,
  input  wire logic                 in_last,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output pcq_pkg::pcq_ctrl_t        push_ctrl,
  output logic [6*(CW+1)-1:0]       push_data
);
  import pcq_pkg::*;

  localparam int unsigned DW = CW + 1;

  typedef enum logic [0:0] {
    F_IDLE,
    F_EMIT
  } fstate_t;

  fstate_t            state_r;
  logic [1:0]         step_r;
  logic [1:0]         seen_r;
  logic               last_r;
  logic signed [CW-1:0] p_r      [3];
  logic signed [CW-1:0] first_r  [3];
  logic signed [CW-1:0] second_r [3];
  logic signed [CW-1:0] older_r  [3];
  logic signed [CW-1:0] newer_r  [3];
  logic signed [CW-1:0] prv      [3];
  logic signed [CW-1:0] at       [3];
  logic signed [CW-1:0] nxt      [3];
  logic               need;
  logic               advance;

  assign in_ready = (state_r == F_IDLE);

  // Choose the corner of the current step and whether it exists.
  always_comb begin
    need      = 1'b0;
    push_ctrl = '{kind: KIND_CORNER, is_tri: 1'b0};
    for (int k = 0; k < 3; k++) begin
      prv[k] = older_r[k];
      at[k]  = newer_r[k];
      nxt[k] = p_r[k];
    end
    case (step_r)
      2'd0: begin
        need = (seen_r >= 2'd2);
      end
      2'd1: begin
        need = last_r && (seen_r != 2'd0);
        for (int k = 0; k < 3; k++) begin
          prv[k] = (seen_r == 2'd1) ? first_r[k] : newer_r[k];
          at[k]  = p_r[k];
          nxt[k] = first_r[k];
        end
      end
      2'd2: begin
        need = last_r && (seen_r != 2'd0);
        for (int k = 0; k < 3; k++) begin
          prv[k] = p_r[k];
          at[k]  = first_r[k];
          nxt[k] = (seen_r == 2'd1) ? p_r[k] : second_r[k];
        end
      end
      default: begin
        need      = last_r;
        push_ctrl = '{kind: KIND_FINISH, is_tri: (seen_r == 2'd2)};
      end
    endcase
  end

  // Edge vectors towards the previous and the next vertex.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      push_data[k*DW +: DW]     = DW'(prv[k]) - DW'(at[k]);
      push_data[(3+k)*DW +: DW] = DW'(nxt[k]) - DW'(at[k]);
    end
  end

  assign push_valid = (state_r == F_EMIT) && need;
  assign advance    = (state_r == F_EMIT) && (!need || push_ready);

  // Sequencer and point registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 2'd0;
      seen_r  <= 2'd0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            for (int k = 0; k < 3; k++) begin
              p_r[k] <= in_pos[k*CW +: CW];
            end
            last_r  <= in_last;
            step_r  <= 2'd0;
            state_r <= F_EMIT;
          end
        end
        F_EMIT: begin
          if (advance) begin
            step_r <= step_r + 2'd1;
            if (step_r == 2'd3) begin
              state_r <= F_IDLE;
              for (int k = 0; k < 3; k++) begin
                if (seen_r == 2'd0) begin
                  first_r[k] <= p_r[k];
                end else if (seen_r == 2'd1) begin
                  second_r[k] <= p_r[k];
                  older_r[k]  <= first_r[k];
                  newer_r[k]  <= p_r[k];
                end else begin
                  older_r[k] <= newer_r[k];
                  newer_r[k] <= p_r[k];
                end
              end
              if (last_r) begin
                seen_r <= 2'd0;
              end else if (seen_r != 2'd3) begin
                seen_r <= seen_r + 2'd1;
              end
            end
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/pcq_back.sv =====
// Back part: evaluates one corner at a time with a shared multiplier,
// a shift-add multiplier, a restoring divider and a digit-by-digit root,
// keeps the minimum and issues the polygon result. Uses pcq_pkg.
`default_nettype none

module pcq_back #(
  parameter int unsigned CW = 16,
  parameter int unsigned FW = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire pcq_pkg::pcq_ctrl_t pop_ctrl,
  input  wire logic [6*(CW+1)-1:0] pop_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [FW+1:0]           out_quality
);
  import pcq_pkg::*;

  localparam int unsigned DW   = CW + 1;
  localparam int unsigned LW   = 2 * DW;
  localparam int unsigned SW   = LW + 1;
  localparam int unsigned GW   = 2 * LW;
  localparam int unsigned QW   = 2 * FW + 1;
  localparam int unsigned RW   = 2 * FW + 2;
  localparam int unsigned CMAX = (LW > QW) ? LW : QW;
  localparam int unsigned CNTW = $clog2(CMAX + 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_PROD,
    B_CHK,
    B_MSQ,
    B_MDEN,
    B_DIV,
    B_SQRT,
    B_UPD
  } bstate_t;

  bstate_t              state_r;
  logic [CNTW-1:0]      cnt_r;
  logic signed [DW-1:0] a_r [3];
  logic signed [DW-1:0] b_r [3];
  logic [LW-1:0]        l1_r;
  logic [LW-1:0]        l2_r;
  logic signed [SW-1:0] d_r;
  logic [GW-1:0]        mcand_r;
  logic [LW-1:0]        mplier_r;
  logic [GW-1:0]        acc_r;
  logic [GW-1:0]        d2_r;
  logic [GW-1:0]        den_r;
  logic [GW-1:0]        rem_r;
  logic [QW-1:0]        q_r;
  logic [RW-1:0]        op_r;
  logic [RW-1:0]        res_r;
  logic [RW-1:0]        one_r;
  logic [FW:0]          worst_r;
  logic                 out_valid_r;
  logic [FW+1:0]        out_quality_r;

  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [LW-1:0] prod;
  logic [LW-1:0]        abs_d;
  logic [GW:0]          div_t;
  logic [RW-1:0]        sq_sum;
  logic [FW:0]          root_up;
  logic [FW:0]          corner_q;
  logic                 out_free;
  logic                 finish_take;

  assign out_valid   = out_valid_r;
  assign out_quality = out_quality_r;
  assign out_free    = !out_valid_r || out_ready;
  assign pop_ready   = (state_r == B_IDLE) &&
                       ((pop_ctrl.kind == KIND_CORNER) || out_free);
  assign finish_take = (state_r == B_IDLE) && pop_valid && pop_ready &&
                       (pop_ctrl.kind == KIND_FINISH);

  // One product per cycle: squares of a, squares of b, then a times b.
  always_comb begin
    mul_a = a_r[0];
    mul_b = a_r[0];
    case (cnt_r)
      CNTW'(1): begin mul_a = a_r[1]; mul_b = a_r[1]; end
      CNTW'(2): begin mul_a = a_r[2]; mul_b = a_r[2]; end
      CNTW'(3): begin mul_a = b_r[0]; mul_b = b_r[0]; end
      CNTW'(4): begin mul_a = b_r[1]; mul_b = b_r[1]; end
      CNTW'(5): begin mul_a = b_r[2]; mul_b = b_r[2]; end
      CNTW'(6): begin mul_a = a_r[0]; mul_b = b_r[0]; end
      CNTW'(7): begin mul_a = a_r[1]; mul_b = b_r[1]; end
      CNTW'(8): begin mul_a = a_r[2]; mul_b = b_r[2]; end
      default: begin mul_a = a_r[0]; mul_b = a_r[0]; end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign abs_d    = d_r[SW-1] ? LW'(-d_r) : LW'(d_r);
  assign div_t    = {rem_r, ((cnt_r == '0) ? d2_r[0] : 1'b0)};
  assign sq_sum   = res_r + one_r;
  assign root_up  = res_r[FW:0] + {{FW{1'b0}}, (op_r != '0)};
  assign corner_q = ((FW+1)'(1) << FW) - root_up;

  // Corner sequencer, running minimum and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      worst_r     <= (FW+1)'(1) << FW;
      cnt_r       <= '0;
    end else begin
      if (finish_take) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop_valid && pop_ready) begin
            if (pop_ctrl.kind == KIND_FINISH) begin
              out_quality_r <= pop_ctrl.is_tri ? {worst_r, 1'b0} : {1'b0, worst_r};
              worst_r       <= (FW+1)'(1) << FW;
            end else begin
              for (int k = 0; k < 3; k++) begin
                a_r[k] <= pop_data[k*DW +: DW];
                b_r[k] <= pop_data[(3+k)*DW +: DW];
              end
              l1_r    <= '0;
              l2_r    <= '0;
              d_r     <= '0;
              cnt_r   <= '0;
              state_r <= B_PROD;
            end
          end
        end
        B_PROD: begin
          if (cnt_r < CNTW'(3)) begin
            l1_r <= l1_r + LW'(prod);
          end else if (cnt_r < CNTW'(6)) begin
            l2_r <= l2_r + LW'(prod);
          end else begin
            d_r <= d_r + SW'(prod);
          end
          cnt_r <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(8)) begin
            state_r <= B_CHK;
          end
        end
        B_CHK: begin
          // A zero-length edge leaves the minimum alone.
          if ((l1_r == '0) || (l2_r == '0)) begin
            state_r <= B_IDLE;
          end else begin
            mcand_r  <= GW'(abs_d);
            mplier_r <= abs_d;
            acc_r    <= '0;
            cnt_r    <= '0;
            state_r  <= B_MSQ;
          end
        end
        B_MSQ, B_MDEN: begin
          if (cnt_r == CNTW'(LW - 1)) begin
            cnt_r <= '0;
            if (state_r == B_MSQ) begin
              d2_r     <= mplier_r[0] ? acc_r + mcand_r : acc_r;
              mcand_r  <= GW'(l1_r);
              mplier_r <= l2_r;
              acc_r    <= '0;
              state_r  <= B_MDEN;
            end else begin
              den_r   <= mplier_r[0] ? acc_r + mcand_r : acc_r;
              rem_r   <= d2_r >> 1;
              q_r     <= '0;
              state_r <= B_DIV;
            end
          end else begin
            if (mplier_r[0]) begin
              acc_r <= acc_r + mcand_r;
            end
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
            cnt_r    <= cnt_r + CNTW'(1);
          end
        end
        B_DIV: begin
          // Quotient of d^2 * 2^(2F) by |a|^2 |b|^2, one bit per cycle.
          if (div_t >= {1'b0, den_r}) begin
            rem_r <= GW'(div_t - {1'b0, den_r});
            q_r   <= {q_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= div_t[GW-1:0];
            q_r   <= {q_r[QW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(QW - 1)) begin
            state_r <= B_SQRT;
          end
        end
        B_SQRT: begin
          // First cycle rounds the quotient up and starts the root.
          if (cnt_r == CNTW'(QW)) begin
            op_r  <= RW'(q_r) + RW'(rem_r != '0);
            res_r <= '0;
            one_r <= RW'(1) << (2 * FW);
            cnt_r <= '0;
          end else begin
            if (op_r >= sq_sum) begin
              op_r  <= op_r - sq_sum;
              res_r <= (res_r >> 1) + one_r;
            end else begin
              res_r <= res_r >> 1;
            end
            one_r <= one_r >> 2;
            cnt_r <= cnt_r + CNTW'(1);
            if (cnt_r == CNTW'(FW)) begin
              state_r <= B_UPD;
            end
          end
        end
        B_UPD: begin
          if (corner_q < worst_r) begin
            worst_r <= corner_q;
          end
          state_r <= B_IDLE;
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/polygon_corner_quality.sv =====
// Polygon corner quality: minimum of 1 - |cos| over all corners of a polygon,
// doubled for a triangle. The front takes one vertex at a time; the back
// evaluates one corner at a time with the shift-add multiplier, the divider
// and the root unit, and skips them when an edge has zero length.
// Reset (rst_n low, synchronous) empties the queue and clears all polygon state.
`default_nettype none

module polygon_corner_quality #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // pos_x, pos_y, pos_z from the lowest bit up
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  wire logic                                  in_tlast,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // quality
  output logic [((FRAC_BITS+2+7)/8)*8-1:0]           out_tdata
);
  import pcq_pkg::*;

  localparam int unsigned DW   = COORD_BITS + 1;
  localparam int unsigned JW   = 6 * DW;
  localparam int unsigned OW   = ((FRAC_BITS + 2 + 7) / 8) * 8;

  logic                  push_valid;
  logic                  push_ready;
  pcq_ctrl_t             push_ctrl;
  logic [JW-1:0]         push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [JW+CTRL_BITS-1:0] pop_word;
  pcq_ctrl_t             pop_ctrl;
  logic [FRAC_BITS+1:0]  quality;

  // Vertex intake and corner job issue.
  pcq_front #(.CW(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pos     (in_tdata[3*COORD_BITS-1:0]),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctrl  (push_ctrl),
    .push_data  (push_data)
  );

  // Job queue.
  pcq_fifo #(.WIDTH(JW + CTRL_BITS)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  ({push_ctrl, push_data}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  assign pop_ctrl = pcq_ctrl_t'(pop_word[JW +: CTRL_BITS]);

  // Corner evaluation and result.
  pcq_back #(.CW(COORD_BITS), .FW(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_ctrl    (pop_ctrl),
    .pop_data    (pop_word[JW-1:0]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_quality (quality)
  );

  assign out_tdata = OW'(quality);

endmodule

`default_nettype wire

// ===== src/pcq_checker.sv =====
// Port-level checks for the polygon corner quality block, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module pcq_checker #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [((3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input wire logic                              in_tlast,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [((FRAC_BITS+2+7)/8)*8-1:0]  out_tdata
);

  localparam int unsigned OW = ((FRAC_BITS + 2 + 7) / 8) * 8;

  // A waiting result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Quality never exceeds two in Q2.F.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= (OW'(1) << (FRAC_BITS + 1))))
    else $error("quality out of range");

  // Reset leaves no result pending.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The front works on one vertex at a time.
  a_one_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("vertex taken while front busy");

  // An offered vertex word carries known coordinates and flag.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown({in_tlast, in_tdata[3*COORD_BITS-1:0]}))
    else $error("unknown vertex word offered");

endmodule

bind polygon_corner_quality pcq_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_pcq_checker (.*);

`default_nettype wire

// ===== tb/sv/polygon_corner_quality_check.sv =====
// Checker for the polygon corner quality block: watches both stream channels,
// predicts the quality word of each polygon and compares it with the block.
// Depends on nothing but the port widths of polygon_corner_quality.
`default_nettype none

module polygon_corner_quality_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  // pos_x, pos_y, pos_z from the lowest bit up
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  // quality
  input  wire logic [23:0] out_tdata,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int ONE_Q = 1 << FRAC;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  point_t    first_pt, second_pt, older_pt, newer_pt;
  int        seen_cnt;
  int        worst_q;
  logic [23:0] quality_fifo [$];
  int        words_checked;

  // Corner quality truncated to FRAC bits, or -1 when an edge has zero length.
  function automatic int corner_quality(point_t prev, point_t at, point_t next);
    longint ax, ay, az, bx, by, bz, dot, la, lb;
    logic [127:0] num, den, sq;
    longint lo, hi, mid;
    ax = longint'(prev.x) - longint'(at.x);
    ay = longint'(prev.y) - longint'(at.y);
    az = longint'(prev.z) - longint'(at.z);
    bx = longint'(next.x) - longint'(at.x);
    by = longint'(next.y) - longint'(at.y);
    bz = longint'(next.z) - longint'(at.z);
    la = ax * ax + ay * ay + az * az;
    lb = bx * bx + by * by + bz * bz;
    dot = ax * bx + ay * by + az * bz;
    if (la == 0 || lb == 0) begin
      return -1;
    end
    if (dot < 0) dot = -dot;
    num = 128'(dot) * 128'(dot);
    num = num << (2 * FRAC);
    den = 128'(la) * 128'(lb);
    // Smallest m with m^2 * den >= num, i.e. the ceiling of |cos| scaled.
    lo = 0;
    hi = ONE_Q;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      sq = 128'(mid * mid) * den;
      if (sq >= num) hi = mid;
      else lo = mid + 1;
    end
    return ONE_Q - int'(lo);
  endfunction

  function automatic void fold_corner(point_t p, point_t a, point_t n);
    int q;
    q = corner_quality(p, a, n);
    if (q >= 0 && q < worst_q) worst_q = q;
  endfunction

  // Advance the polygon state by one vertex; returns 1 when a word is due.
  function automatic bit take_vertex(point_t p, bit last, output logic [23:0] word);
    bit tri_poly;
    tri_poly = 0;
    word = '0;
    if (seen_cnt == 0) begin
      first_pt = p;
    end else if (seen_cnt == 1) begin
      second_pt = p;
      older_pt = first_pt;
      newer_pt = p;
      if (last) begin
        fold_corner(first_pt, p, first_pt);
        fold_corner(p, first_pt, p);
      end
    end else begin
      tri_poly = last && seen_cnt == 2;
      fold_corner(older_pt, newer_pt, p);
      older_pt = newer_pt;
      newer_pt = p;
      if (last) begin
        fold_corner(older_pt, p, first_pt);
        fold_corner(p, first_pt, second_pt);
      end
    end
    if (seen_cnt < 3) seen_cnt++;
    if (!last) return 0;
    word = 24'(tri_poly ? worst_q * 2 : worst_q);
    seen_cnt = 0;
    worst_q = ONE_Q;
    first_pt = '0;
    second_pt = '0;
    older_pt = '0;
    newer_pt = '0;
    return 1;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    seen_cnt = 0;
    worst_q = ONE_Q;
    words_checked = 0;
  end

  // Both channels are sampled at the clock edge, before the block updates.
  always @(posedge clk) begin
    logic [23:0] word;
    logic [23:0] want;
    if (!rst_n) begin
      seen_cnt = 0;
      worst_q = ONE_Q;
      quality_fifo.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (take_vertex(point_t'(in_tdata), in_tlast, word)) quality_fifo = {quality_fifo, word};
      end
      if (out_tvalid && out_tready) begin
        if (quality_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected quality word %0h", out_tdata));
        end else begin
          want = quality_fifo.pop_front();
          if (out_tdata !== want)
            report_mismatch($sformatf("word %0d quality %0h, predicted %0h",
                                      words_checked, out_tdata, want));
          words_checked++;
        end
      end
    end
    pending = quality_fifo.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/polygon_corner_quality_test.sv =====
// Top of the polygon corner quality testbench: clock, reset, polygon stimulus,
// receiver stalls and the verdict. Depends on polygon_corner_quality and
// polygon_corner_quality_check.
`default_nettype none

module polygon_corner_quality_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int TAIL_CYCLES = 1500;
  localparam int RANDOM_VERTICES = 1250;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  int          errors;
  int          pending;

  int cycle_cnt;
  int burst_left;
  int hold_cycles;
  int vertex_cnt;
  int polygon_cnt;

  polygon_corner_quality dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  polygon_corner_quality_check checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("polygon_corner_quality_test NOT OK");
        $finish;
      end
    end
  end

  // Receiver: random stall pattern in phases, plus an occasional long hold.
  initial begin
    int mode;
    int phase_left;
    out_tready = 1'b0;
    hold_cycles = 0;
    mode = 0;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Offer one vertex word and wait until it is taken; bursts with random gaps.
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    vertex_cnt++;
    if (last) polygon_cnt++;
  endtask

  function automatic logic [15:0] rand_coord(int spread);
    case (spread)
      0: return 16'($urandom_range(0, 15)) - 16'sd8;
      1: return 16'($urandom_range(0, 2047)) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_polygon();
    int n;
    int spread;
    logic [15:0] px, py, pz;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
    spread = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      // Occasionally repeat the previous vertex to make a zero-length edge.
      if (i == 0 || $urandom_range(0, 11) != 0) begin
        px = rand_coord(spread);
        py = rand_coord(spread);
        pz = rand_coord(spread);
      end
      send_vertex(px, py, pz, i == n - 1);
    end
  endtask

  initial begin
    int hold_at;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    burst_left = 0;
    vertex_cnt = 0;
    polygon_cnt = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single vertex, two distinct and two equal points.
    send_vertex(16'sd5, -16'sd3, 16'sd7, 1);
    send_vertex(16'sd0, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd1, 16'sd2, 16'sd3, 1);
    send_vertex(16'sd9, 16'sd9, 16'sd9, 0);
    send_vertex(16'sd9, 16'sd9, 16'sd9, 1);
    // Right triangle, doubled, and a triangle with the extreme coordinates.
    send_vertex(16'sd0, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd4, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd0, 16'sd4, 16'sd0, 1);
    send_vertex(-16'sd32768, -16'sd32768, -16'sd32768, 0);
    send_vertex(16'sd32767, 16'sd32767, -16'sd32768, 0);
    send_vertex(-16'sd32768, 16'sd32767, 16'sd32767, 1);
    // Square, then a polygon with a repeated vertex and a collinear corner.
    send_vertex(16'sd0, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd10, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd10, 16'sd10, 16'sd0, 0);
    send_vertex(16'sd0, 16'sd10, 16'sd0, 1);
    send_vertex(16'sd0, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd0, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd5, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd10, 16'sd0, 16'sd0, 0);
    send_vertex(16'sd3, 16'sd8, -16'sd2, 1);
    // Extreme corners of the cube as a quadrilateral.
    send_vertex(16'sd32767, 16'sd32767, 16'sd32767, 0);
    send_vertex(-16'sd32768, 16'sd32767, 16'sd32767, 0);
    send_vertex(-16'sd32768, -16'sd32768, 16'sd32767, 0);
    send_vertex(16'sd32767, -16'sd32768, -16'sd32768, 1);

    // Sender pauses until every quality word has come back.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random polygons; partway through the receiver holds off for long.
    hold_at = RANDOM_VERTICES / 3;
    while (vertex_cnt < RANDOM_VERTICES) begin
      if (hold_at > 0 && vertex_cnt >= hold_at) begin
        hold_cycles = 4000;
        hold_at = 0;
      end
      random_polygon();
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d polygons with %0d vertices, single to octagon, with stalls",
             polygon_cnt, vertex_cnt);
    if (errors == 0) begin
      $display("polygon_corner_quality_test OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("polygon_corner_quality_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
